// ===== hw/rtl/fadst_pkg.sv =====
// ----------------------------------------------------------------------------
// fadst_pkg: shared types and constants
// Command types, stream constants and the CRC-12 step for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none
package fadst_pkg;

	localparam int NUM_CH = 8;
	localparam int NUM_AMP = 64;
	localparam int AMP_AW = 9;
	localparam int SUM_W = 44;
	localparam int SQ_W = 56;
	localparam int VAL_W = 12;

	localparam logic [11:0] CRC12_TAPS = 12'h80F;
	localparam logic [11:0] VAL_MAX = 12'hFFF;
	localparam logic [3:0] TAG_HDR = 4'hE;
	localparam logic [3:0] TAG_D = 4'hD;
	localparam logic [3:0] TAG_DATA = 4'h0;
	localparam logic [3:0] TAG_TRL = 4'hC;
	localparam logic [15:0] SYNC_L0 = 16'hFA35;
	localparam logic [15:0] SYNC_L1 = 16'hFB46;
	localparam logic [15:0] SYNC_L2 = 16'hFC57;
	localparam logic [15:0] SYNC_L3 = 16'hFD68;
	localparam logic [11:0] CENTER_RST = 12'd2048;
	localparam logic [11:0] DIST_RST = 12'd500;

	// Configuration register indexes.
	localparam logic CFG_CENTER = 1'b0;
	localparam logic CFG_DIST = 1'b1;

	// Result kinds on the output tuser.
	localparam logic [1:0] RES_GOOD = 2'd0;
	localparam logic [1:0] RES_CRC = 2'd1;
	localparam logic [1:0] RES_READ = 2'd2;

	// Statistic selectors for read requests.
	localparam logic [3:0] ST_SUM = 4'd0;
	localparam logic [3:0] ST_SQ = 4'd1;
	localparam logic [3:0] ST_CNT = 4'd2;
	localparam logic [3:0] ST_MIN = 4'd3;
	localparam logic [3:0] ST_MAX = 4'd4;
	localparam logic [3:0] ST_OUTL = 4'd5;
	localparam logic [3:0] ST_A_SUM = 4'd6;
	localparam logic [3:0] ST_A_SQ = 4'd7;
	localparam logic [3:0] ST_A_CNT = 4'd8;
	localparam logic [3:0] ST_A_OUTL = 4'd9;
	localparam logic [3:0] ST_GOOD = 4'd10;
	localparam logic [3:0] ST_CRCERR = 4'd11;

	typedef enum logic [1:0] {
		CMD_READ,
		CMD_GOOD,
		CMD_BAD
	} cmd_kind_e;

	typedef struct packed {
		cmd_kind_e kind;
		logic [1:0] lane;
		logic [2:0] ch;
		logic [5:0] amp;
		logic [3:0] stat;
	} cmd_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_RD,
		B_CALC,
		B_WR,
		B_RESP
	} back_state_e;

	// One CRC-12 word step, MSB first over the 12 value bits.
	function automatic logic [11:0] crc_feed(input logic [11:0] crc_in,
		input logic [11:0] val);
		logic [11:0] c;
		logic fb;
		c = crc_in;
		for (int b = 11; b >= 0; b--) begin
			fb = val[b] ^ c[11];
			c = {c[10:0], 1'b0};
			if (fb) begin
				c = c ^ CRC12_TAPS;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/framed_adc_deframer_stats_top.sv =====
// ----------------------------------------------------------------------------
// Path: with the back end idle, a bad trailer loads the output register when
// popped, a read goes through B_RESP first, and a good trailer first commits
// the frame, each word through B_RD, B_CALC and B_WR.
// Throughput: one word per cycle within a frame while the command queue has
// room; a good trailer stalls input until its commit completes.
// Reset: asynchronous; then a clearing pass of the amplifier memory during
// which no item is accepted (configuration writes still are).
// ----------------------------------------------------------------------------
// framed_adc_deframer_stats_top: CRC-checked deframer with statistics
// Front end deframes, a short queue decouples, back end keeps statistics.
// ----------------------------------------------------------------------------
`default_nettype none
module framed_adc_deframer_stats_top #(
	parameter int FRAME_DATA_WORDS = 128,
	parameter int COUNTER_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // word, read_channel, read_amp, read_stat
	input wire logic s_tuser, // req_type
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [63:0] m_tdata, // frame_lane, read_value
	output logic [1:0] m_tuser, // result_kind
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [11:0] cfg_data
);

	localparam int AW = $clog2(FRAME_DATA_WORDS);

	logic [11:0] center_q;
	logic [11:0] distance_q;
	logic q_push, q_full, q_pop, q_nonempty;
	fadst_pkg::cmd_t push_cmd, head_cmd;
	logic fb_we;
	logic [AW-1:0] fb_waddr;
	logic [11:0] fb_wdata;
	logic clr_busy, commit_done;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= fadst_pkg::CENTER_RST;
			distance_q <= fadst_pkg::DIST_RST;
		end else if (cfg_valid) begin
			if (cfg_index == fadst_pkg::CFG_CENTER) begin
				center_q <= cfg_data;
			end else begin
				distance_q <= cfg_data;
			end
		end
	end

	fadst_front #(.FRAME_DATA_WORDS(FRAME_DATA_WORDS), .AW(AW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_type(s_tuser),
		.in_word(s_tdata[15:0]), .in_ch(s_tdata[18:16]), .in_amp(s_tdata[24:19]),
		.in_stat(s_tdata[28:25]),
		.clr_busy(clr_busy), .commit_done(commit_done),
		.q_full(q_full), .q_push(q_push), .q_cmd(push_cmd),
		.fb_we(fb_we), .fb_waddr(fb_waddr), .fb_wdata(fb_wdata)
	);

	fadst_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_cmd(push_cmd), .full(q_full),
		.pop(q_pop), .nonempty(q_nonempty), .head(head_cmd)
	);

	fadst_back #(.FRAME_DATA_WORDS(FRAME_DATA_WORDS), .AW(AW),
		.COUNTER_BITS(COUNTER_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_nonempty), .q_cmd(head_cmd), .q_pop(q_pop),
		.fb_we(fb_we), .fb_waddr(fb_waddr), .fb_wdata(fb_wdata),
		.center(center_q), .distance(distance_q),
		.clr_busy(clr_busy), .commit_done(commit_done),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_kind(m_tuser), .out_data(m_tdata)
	);

	// The queue never takes an item it has no room for.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("command queue overflow");

	// Input is held off in the cycle in which a commit completes.
	a_commit_stall: assert property (@(posedge clk) disable iff (!arst_n)
		commit_done |-> !s_tready) else $error("input accepted during commit");

	// Nothing is popped and no input is accepted during the clearing pass.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !q_pop && !s_tready) else $error("activity while clearing");

endmodule
`default_nettype wire

// ===== hw/rtl/fadst_queue.sv =====
// ----------------------------------------------------------------------------
// fadst_queue: two-entry command queue
// Decouples the framing front end from the statistics back end.
// ----------------------------------------------------------------------------
`default_nettype none
module fadst_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire fadst_pkg::cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output logic nonempty,
	output fadst_pkg::cmd_t head
);

	fadst_pkg::cmd_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign head = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/fadst_front.sv =====
// ----------------------------------------------------------------------------
// fadst_front: sync hunt, framing and CRC check
// Accepts items, tracks the frame, writes data words to the frame buffer
// and queues read requests and frame verdicts for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module fadst_front #(
	parameter int FRAME_DATA_WORDS = 128,
	parameter int AW = 7
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic in_type,
	input wire logic [15:0] in_word,
	input wire logic [2:0] in_ch,
	input wire logic [5:0] in_amp,
	input wire logic [3:0] in_stat,
	input wire logic clr_busy,
	input wire logic commit_done,
	input wire logic q_full,
	output logic q_push,
	output fadst_pkg::cmd_t q_cmd,
	output logic fb_we,
	output logic [AW-1:0] fb_waddr,
	output logic [11:0] fb_wdata
);

	localparam int PW = $clog2(FRAME_DATA_WORDS + 4);
	localparam logic [PW-1:0] TRAIL = PW'(FRAME_DATA_WORDS + 3);

	logic in_frame_q;
	logic [PW-1:0] pos_q;
	logic [1:0] lane_q;
	logic [11:0] crc_q;
	logic pend_q;

	logic acc;
	logic [3:0] tag;
	logic [11:0] val;
	logic hit;
	logic [1:0] hit_lane;
	logic [3:0] want;
	logic in_frame_d;
	logic [PW-1:0] pos_d;
	logic [1:0] lane_d;
	logic [11:0] crc_d;
	logic set_pend;

	// Held off while the command queue is full, a frame commits or the statistics memory clears.
	assign in_ready = !q_full && !pend_q && !clr_busy;
	assign acc = in_valid && in_ready;
	assign tag = in_word[15:12];
	assign val = in_word[11:0];

	// Sync word match against the four lanes.
	always_comb begin
		hit = 1'b1;
		hit_lane = 2'd0;
		case (in_word)
			fadst_pkg::SYNC_L0: hit_lane = 2'd0;
			fadst_pkg::SYNC_L1: hit_lane = 2'd1;
			fadst_pkg::SYNC_L2: hit_lane = 2'd2;
			fadst_pkg::SYNC_L3: hit_lane = 2'd3;
			default: hit = 1'b0;
		endcase
	end

	// Frame tracking for one accepted item.
	always_comb begin
		in_frame_d = in_frame_q;
		pos_d = pos_q;
		lane_d = lane_q;
		crc_d = crc_q;
		q_push = 1'b0;
		q_cmd = '{kind: fadst_pkg::CMD_READ, lane: lane_q, ch: in_ch, amp: in_amp,
			stat: in_stat};
		fb_we = 1'b0;
		fb_waddr = AW'(pos_q - PW'(3));
		fb_wdata = val;
		set_pend = 1'b0;
		if (pos_q == PW'(1)) begin
			want = fadst_pkg::TAG_HDR;
		end else if (pos_q == PW'(2)) begin
			want = fadst_pkg::TAG_D;
		end else begin
			want = fadst_pkg::TAG_DATA;
		end
		if (acc) begin
			if (in_type) begin
				q_push = 1'b1;
			end else if (!in_frame_q) begin
				if (hit) begin
					in_frame_d = 1'b1;
					pos_d = PW'(1);
					lane_d = hit_lane;
					crc_d = fadst_pkg::crc_feed(12'd0, val);
				end
			end else if (pos_q < TRAIL) begin
				if (tag != want) begin
					in_frame_d = 1'b0;
				end else begin
					fb_we = (pos_q >= PW'(3));
					crc_d = fadst_pkg::crc_feed(crc_q, val);
					pos_d = pos_q + PW'(1);
				end
			end else begin
				in_frame_d = 1'b0;
				q_push = 1'b1;
				if (tag == fadst_pkg::TAG_TRL && val == crc_q) begin
					q_cmd.kind = fadst_pkg::CMD_GOOD;
					set_pend = 1'b1;
				end else begin
					q_cmd.kind = fadst_pkg::CMD_BAD;
				end
			end
		end
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q <= '0;
			lane_q <= 2'd0;
			crc_q <= 12'd0;
			pend_q <= 1'b0;
		end else begin
			in_frame_q <= in_frame_d;
			pos_q <= pos_d;
			lane_q <= lane_d;
			crc_q <= crc_d;
			if (set_pend) begin
				pend_q <= 1'b1;
			end else if (commit_done) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/fadst_back.sv =====
// ----------------------------------------------------------------------------
// fadst_back: statistics engine
// Commits good frames word by word into channel and amplifier statistics,
// answers read requests and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module fadst_back #(
	parameter int FRAME_DATA_WORDS = 128,
	parameter int AW = 7,
	parameter int COUNTER_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire fadst_pkg::cmd_t q_cmd,
	output logic q_pop,
	input wire logic fb_we,
	input wire logic [AW-1:0] fb_waddr,
	input wire logic [11:0] fb_wdata,
	input wire logic [11:0] center,
	input wire logic [11:0] distance,
	output logic clr_busy,
	output logic commit_done,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] out_kind,
	output logic [63:0] out_data
);

	localparam int CB = COUNTER_BITS;
	localparam int SW = fadst_pkg::SUM_W;
	localparam int QW = fadst_pkg::SQ_W;
	localparam int MW = fadst_pkg::AMP_AW;

	fadst_pkg::back_state_e state_q, state_d;

	// Frame buffer and amplifier statistics memories.
	logic [11:0] fb_mem [FRAME_DATA_WORDS];
	logic [SW-1:0] a_sum_mem [2**MW];
	logic [QW-1:0] a_sq_mem [2**MW];
	logic [CB-1:0] a_cnt_mem [2**MW];
	logic [CB-1:0] a_outl_mem [2**MW];

	logic [11:0] fb_rd_q;
	logic [SW-1:0] a_sum_rd_q;
	logic [QW-1:0] a_sq_rd_q;
	logic [CB-1:0] a_cnt_rd_q;
	logic [CB-1:0] a_outl_rd_q;

	// Channel statistics registers.
	logic [SW-1:0] c_sum_q [fadst_pkg::NUM_CH];
	logic [QW-1:0] c_sq_q [fadst_pkg::NUM_CH];
	logic [CB-1:0] c_cnt_q [fadst_pkg::NUM_CH];
	logic [11:0] c_min_q [fadst_pkg::NUM_CH];
	logic [11:0] c_max_q [fadst_pkg::NUM_CH];
	logic [CB-1:0] c_outl_q [fadst_pkg::NUM_CH];
	logic [CB-1:0] good_q;
	logic [CB-1:0] crcerr_q;

	logic [MW-1:0] clr_q;
	logic [AW-1:0] d_q;
	fadst_pkg::cmd_t cmd_q;
	logic [11:0] v_q;
	logic [23:0] sq_q;
	logic outl_q;

	logic out_valid_q;
	logic [1:0] out_kind_q;
	logic [63:0] out_data_q;

	logic [AW+5:0] amp_wide;
	logic amp_ok;
	logic [2:0] cm_ch;
	logic [MW-1:0] cm_addr;
	logic [MW-1:0] amp_raddr;
	logic [2:0] sel_ch;
	logic last;
	logic [11:0] dev;
	logic outl;

	logic [SW:0] c_sum_add, a_sum_add;
	logic [QW:0] c_sq_add, a_sq_add;
	logic [CB:0] c_cnt_add, a_cnt_add, c_outl_add, a_outl_add;
	logic [CB:0] good_add, crcerr_add;
	logic [SW-1:0] c_sum_new, a_sum_new;
	logic [QW-1:0] c_sq_new, a_sq_new;
	logic [CB-1:0] c_cnt_new, a_cnt_new, c_outl_new, a_outl_new;
	logic [CB-1:0] good_new, crcerr_new;
	logic [QW-1:0] rd_val;
	logic load_frame;

	assign out_valid = out_valid_q;
	assign out_kind = out_kind_q;
	assign out_data = out_data_q;
	assign clr_busy = (state_q == fadst_pkg::B_CLEAR);

	// Commit addressing: data word d goes to channel lane*2+d[0], amp d/2.
	assign amp_wide = {6'd0, d_q} >> 1;
	assign amp_ok = (amp_wide < (AW+6)'(fadst_pkg::NUM_AMP));
	assign cm_ch = {cmd_q.lane, d_q[0]};
	assign cm_addr = {cm_ch, amp_wide[5:0]};
	assign last = (d_q == AW'(FRAME_DATA_WORDS - 1));
	assign amp_raddr = (state_q == fadst_pkg::B_IDLE) ? {q_cmd.ch, q_cmd.amp} : cm_addr;
	assign sel_ch = (state_q == fadst_pkg::B_RESP) ? cmd_q.ch : cm_ch;

	// Outlier distance of the word just read from the frame buffer.
	assign dev = (fb_rd_q >= center) ? (fb_rd_q - center) : (center - fb_rd_q);
	assign outl = (dev > distance);

	// Saturating updates.
	always_comb begin
		c_sum_add = {1'b0, c_sum_q[sel_ch]} + (SW+1)'(v_q);
		a_sum_add = {1'b0, a_sum_rd_q} + (SW+1)'(v_q);
		c_sq_add = {1'b0, c_sq_q[sel_ch]} + (QW+1)'(sq_q);
		a_sq_add = {1'b0, a_sq_rd_q} + (QW+1)'(sq_q);
		c_cnt_add = {1'b0, c_cnt_q[sel_ch]} + (CB+1)'(1);
		a_cnt_add = {1'b0, a_cnt_rd_q} + (CB+1)'(1);
		c_outl_add = {1'b0, c_outl_q[sel_ch]} + (CB+1)'(1);
		a_outl_add = {1'b0, a_outl_rd_q} + (CB+1)'(1);
		good_add = {1'b0, good_q} + (CB+1)'(1);
		crcerr_add = {1'b0, crcerr_q} + (CB+1)'(1);
		c_sum_new = c_sum_add[SW] ? '1 : c_sum_add[SW-1:0];
		a_sum_new = a_sum_add[SW] ? '1 : a_sum_add[SW-1:0];
		c_sq_new = c_sq_add[QW] ? '1 : c_sq_add[QW-1:0];
		a_sq_new = a_sq_add[QW] ? '1 : a_sq_add[QW-1:0];
		c_cnt_new = c_cnt_add[CB] ? '1 : c_cnt_add[CB-1:0];
		a_cnt_new = a_cnt_add[CB] ? '1 : a_cnt_add[CB-1:0];
		c_outl_new = c_outl_add[CB] ? '1 : c_outl_add[CB-1:0];
		a_outl_new = a_outl_add[CB] ? '1 : a_outl_add[CB-1:0];
		good_new = good_add[CB] ? '1 : good_add[CB-1:0];
		crcerr_new = crcerr_add[CB] ? '1 : crcerr_add[CB-1:0];
	end

	// Read response value selection.
	always_comb begin
		case (cmd_q.stat)
			fadst_pkg::ST_SUM: rd_val = QW'(c_sum_q[sel_ch]);
			fadst_pkg::ST_SQ: rd_val = c_sq_q[sel_ch];
			fadst_pkg::ST_CNT: rd_val = QW'(c_cnt_q[sel_ch]);
			fadst_pkg::ST_MIN: rd_val = QW'(c_min_q[sel_ch]);
			fadst_pkg::ST_MAX: rd_val = QW'(c_max_q[sel_ch]);
			fadst_pkg::ST_OUTL: rd_val = QW'(c_outl_q[sel_ch]);
			fadst_pkg::ST_A_SUM: rd_val = QW'(a_sum_rd_q);
			fadst_pkg::ST_A_SQ: rd_val = a_sq_rd_q;
			fadst_pkg::ST_A_CNT: rd_val = QW'(a_cnt_rd_q);
			fadst_pkg::ST_A_OUTL: rd_val = QW'(a_outl_rd_q);
			fadst_pkg::ST_GOOD: rd_val = QW'(good_q);
			fadst_pkg::ST_CRCERR: rd_val = QW'(crcerr_q);
			default: rd_val = '0;
		endcase
	end

	// Next state and handshake decisions.
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		load_frame = 1'b0;
		case (state_q)
			fadst_pkg::B_CLEAR: begin
				if (clr_q == '1) begin
					state_d = fadst_pkg::B_IDLE;
				end
			end
			fadst_pkg::B_IDLE: begin
				if (q_valid && (!out_valid_q || out_ready)) begin
					q_pop = 1'b1;
					case (q_cmd.kind)
						fadst_pkg::CMD_READ: state_d = fadst_pkg::B_RESP;
						fadst_pkg::CMD_GOOD: state_d = fadst_pkg::B_RD;
						default: state_d = fadst_pkg::B_IDLE;
					endcase
				end
			end
			fadst_pkg::B_RD: state_d = fadst_pkg::B_CALC;
			fadst_pkg::B_CALC: state_d = fadst_pkg::B_WR;
			fadst_pkg::B_WR: begin
				if (last) begin
					load_frame = 1'b1;
					state_d = fadst_pkg::B_IDLE;
				end else begin
					state_d = fadst_pkg::B_RD;
				end
			end
			fadst_pkg::B_RESP: state_d = fadst_pkg::B_IDLE;
			default: state_d = fadst_pkg::B_IDLE;
		endcase
	end

	assign commit_done = load_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fadst_pkg::B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame buffer: written by the front end, read during commit.
	always_ff @(posedge clk) begin
		if (fb_we) begin
			fb_mem[fb_waddr] <= fb_wdata;
		end
		fb_rd_q <= fb_mem[d_q];
	end

	// Amplifier memories: clearing pass after reset, then commit writes.
	always_ff @(posedge clk) begin
		if (state_q == fadst_pkg::B_CLEAR) begin
			a_sum_mem[clr_q] <= '0;
			a_sq_mem[clr_q] <= '0;
			a_cnt_mem[clr_q] <= '0;
			a_outl_mem[clr_q] <= '0;
		end else if (state_q == fadst_pkg::B_WR && amp_ok) begin
			a_sum_mem[cm_addr] <= a_sum_new;
			a_sq_mem[cm_addr] <= a_sq_new;
			a_cnt_mem[cm_addr] <= a_cnt_new;
			if (outl_q) begin
				a_outl_mem[cm_addr] <= a_outl_new;
			end
		end
		a_sum_rd_q <= a_sum_mem[amp_raddr];
		a_sq_rd_q <= a_sq_mem[amp_raddr];
		a_cnt_rd_q <= a_cnt_mem[amp_raddr];
		a_outl_rd_q <= a_outl_mem[amp_raddr];
	end

	// Per-word operands (value, square, outlier flag), popped command and output payload.
	always_ff @(posedge clk) begin
		if (state_q == fadst_pkg::B_CALC) begin
			v_q <= fb_rd_q;
			sq_q <= fb_rd_q * fb_rd_q;
			outl_q <= outl;
		end
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (load_frame) begin
			out_kind_q <= fadst_pkg::RES_GOOD;
			out_data_q <= 64'(cmd_q.lane);
		end else if (q_pop && q_cmd.kind == fadst_pkg::CMD_BAD) begin
			out_kind_q <= fadst_pkg::RES_CRC;
			out_data_q <= 64'(q_cmd.lane);
		end else if (state_q == fadst_pkg::B_RESP) begin
			out_kind_q <= fadst_pkg::RES_READ;
			out_data_q <= {6'd0, rd_val, 2'd0};
		end
	end

	// Control, counters and channel statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			d_q <= '0;
			out_valid_q <= 1'b0;
			good_q <= '0;
			crcerr_q <= '0;
			for (int c = 0; c < fadst_pkg::NUM_CH; c++) begin
				c_sum_q[c] <= '0;
				c_sq_q[c] <= '0;
				c_cnt_q[c] <= '0;
				c_min_q[c] <= fadst_pkg::VAL_MAX;
				c_max_q[c] <= '0;
				c_outl_q[c] <= '0;
			end
		end else begin
			if (state_q == fadst_pkg::B_CLEAR) begin
				clr_q <= clr_q + MW'(1);
			end
			if (load_frame || state_q == fadst_pkg::B_RESP
				|| (q_pop && q_cmd.kind == fadst_pkg::CMD_BAD)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop && q_cmd.kind == fadst_pkg::CMD_GOOD) begin
				good_q <= good_new;
				d_q <= '0;
			end
			if (q_pop && q_cmd.kind == fadst_pkg::CMD_BAD) begin
				crcerr_q <= crcerr_new;
			end
			if (state_q == fadst_pkg::B_WR) begin
				d_q <= d_q + AW'(1);
				c_sum_q[sel_ch] <= c_sum_new;
				c_sq_q[sel_ch] <= c_sq_new;
				c_cnt_q[sel_ch] <= c_cnt_new;
				if (v_q < c_min_q[sel_ch]) begin
					c_min_q[sel_ch] <= v_q;
				end
				if (v_q > c_max_q[sel_ch]) begin
					c_max_q[sel_ch] <= v_q;
				end
				if (outl_q) begin
					c_outl_q[sel_ch] <= c_outl_new;
				end
			end
		end
	end

endmodule
`default_nettype wire
